FILE: rtl/core/sist_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Shared types and constants for the sorted insert/search table: item
// structs, item kind codes and the structs that run along the chain of cells.
// ----------------------------------------------------------------------------
package sist_pkg;

    localparam int DATA_W  = 32;
    localparam int SUM_W   = 36;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Item kind codes.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    // One result item.
    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic                    found;
        logic                    full_refused;
        logic [COUNT_W-1:0]      entry_count;
        logic signed [SUM_W-1:0] total;
    } rsp_item_t;

    // Operation broadcast to every cell for one cycle.
    typedef struct packed {
        logic                     insert;
        logic                     search;
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    // What one cell hands to the next cell up the chain.
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic                     valid;
        logic                     le;
        logic                     eq;
    } cell_link_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_RES  = 3'b100
    } seq_state_t;

endpackage

FILE: rtl/core/sist_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry and its valid bit. Compares its entry with the
// broadcast value, takes the lower neighbor's entry or the new value on an
// insert, and flags whether it is the slot of interest for the operation.
// ----------------------------------------------------------------------------
module sist_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sist_pkg::cell_ctrl_t ctrl,
    input  sist_pkg::cell_link_t prev,
    output sist_pkg::cell_link_t link,
    output logic                hit
);
    import sist_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic                     le;
    logic                     eq;

    // Local compare against the broadcast value.
    assign le = valid_reg && (entry_reg <= ctrl.value);
    assign eq = valid_reg && (entry_reg == ctrl.value);

    assign link.entry = entry_reg;
    assign link.valid = valid_reg;
    assign link.le    = le;
    assign link.eq    = eq;
    assign hit        = hit_reg;

    // Next entry, valid bit and slot flag.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (ctrl.insert)
        begin
            // Larger entries move up one place; the boundary cell takes the value.
            if (!le)
            begin
                entry_next = prev.le ? ctrl.value : prev.entry;
            end
            valid_next = valid_reg | prev.valid;
            hit_next   = !le && prev.le;
        end
        else if (ctrl.search)
        begin
            // The table is sorted, so the first equal cell follows a non-equal one.
            hit_next = eq && !prev.eq;
        end
        else if (ctrl.clear)
        begin
            valid_next = 1'b0;
            hit_next   = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/core/sorted_insert_search_table_core.sv
// ----------------------------------------------------------------------------
// Sorted insert/search table core
// Keeps up to DEPTH signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req with req_valid; a transfer happens when req_valid
//   is high and req_stall is low. Kind insert places the value after all
//   equal entries, kind search finds the first equal entry, kind clear
//   empties the table. Every request gives exactly one result on rsp.
//   Each request passes through the transfer, a compare step in which every
//   cell compares and shifts at once, and an encode step that loads the
//   slot flags into the result register. The next request is taken in the
//   cycle after the result is loaded, so the block does not take a new
//   request before it is through with the last one.
//   Results sit in an output register. While the receiver stalls, the block
//   still accepts and works one further request, then holds it until the
//   register frees up; req_stall stays high in the meantime.
//   Reset empties the table and clears the count and the running sum; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_insert_search_table_core #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sist_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sist_pkg::rsp_item_t rsp
);
    import sist_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    seq_state_t               state_reg;
    seq_state_t               state_next;
    logic [KIND_W-1:0]        kind_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     refused_reg;
    logic                     refused_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_item_t                rsp_reg;
    rsp_item_t                rsp_next;
    logic                     full;
    logic                     req_xfer;
    logic                     load_rsp;
    cell_ctrl_t               ctrl;
    cell_link_t               links [DEPTH+1];
    logic [DEPTH-1:0]         hits;
    logic [IW-1:0]            pos_enc;
    logic                     hit_op;
    logic                     any_hit;

    assign full      = (count_reg == CW'(DEPTH));
    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign load_rsp  = (state_reg == ST_RES) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Operation broadcast to the cells during the compare cycle.
    always_comb
    begin
        ctrl.value  = value_reg;
        ctrl.insert = (state_reg == ST_CMP) && (kind_reg == KIND_INSERT) && !full;
        ctrl.search = (state_reg == ST_CMP) && (kind_reg == KIND_SEARCH);
        ctrl.clear  = (state_reg == ST_CMP) && (kind_reg == KIND_CLEAR);
    end

    // The bottom of the chain acts as an always-smaller neighbor.
    always_comb
    begin
        links[0].entry = value_reg;
        links[0].valid = 1'b1;
        links[0].le    = 1'b1;
        links[0].eq    = 1'b0;
    end

    // Row of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sist_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (links[i]),
            .link  (links[i+1]),
            .hit   (hits[i])
        );
    end

    // At most one cell flags a slot; merge its index.
    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hits[i])
            begin
                pos_enc = pos_enc | IW'(i);
            end
        end
    end

    // Slot flags are only set by a search or an accepted insert (a clear zeroes
    // them); the unused kind and a refused insert leave older flags in the cells.
    assign hit_op  = (kind_reg == KIND_SEARCH)
                  || ((kind_reg == KIND_INSERT) && !refused_reg);
    assign any_hit = hit_op && (|hits);

    // Count, running sum and refusal flag.
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        refused_next = refused_reg;
        if (state_reg == ST_CMP)
        begin
            refused_next = (kind_reg == KIND_INSERT) && full;
            if (ctrl.insert)
            begin
                count_next = count_reg + CW'(1);
                sum_next   = sum_reg + SUM_W'(value_reg);
            end
            else if (ctrl.clear)
            begin
                count_next = '0;
                sum_next   = '0;
            end
        end
    end

    // Result assembly.
    always_comb
    begin
        rsp_next              = rsp_reg;
        rsp_valid_next        = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_next.position     = any_hit ? POS_W'(pos_enc) : '0;
            rsp_next.found        = any_hit;
            rsp_next.full_refused = refused_reg;
            rsp_next.entry_count  = COUNT_W'(count_reg);
            rsp_next.total        = sum_reg;
            rsp_valid_next        = 1'b1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            refused_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            refused_reg   <= refused_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg  <= req.kind;
            value_reg <= req.value;
        end
        rsp_reg <= rsp_next;
    end

endmodule
